[hdl/i2cst_pkg.sv]
// Shared types, constants and the transaction programme tables for the sensor I2C master.
package i2cst_pkg;

	localparam int unsigned PHASE_W   = 5;
	localparam int unsigned SUB_W     = 3;
	localparam int unsigned BITCNT_W  = 4;
	localparam int unsigned DELAY_W   = 10;
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 10;

	localparam logic [7:0] ADDR_WR_MASK = 8'hfe;
	localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_REGISTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS     = 2'd2;

	typedef enum logic [3:0] {
		SEG_END        = 4'd0,
		SEG_START      = 4'd1,
		SEG_WR_ADDR_W  = 4'd2,
		SEG_WR_ADDR_R  = 4'd3,
		SEG_WR_OPERAND = 4'd4,
		SEG_WR_CMDREG  = 4'd5,
		SEG_ACK        = 4'd6,
		SEG_RD         = 4'd7,
		SEG_MACK       = 4'd8,
		SEG_NACK       = 4'd9,
		SEG_STOP       = 4'd10,
		SEG_SETTLE     = 4'd11,
		SEG_WAITSCL    = 4'd12
	} seg_t;

	typedef struct packed {
		logic [7:0]          device_address;
		logic [7:0]          command_register;
		logic [DELAY_W-1:0]  settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic       func;
		logic       start_request;
		logic [7:0] operand_byte;
		logic       sda_sample;
		logic       scl_sample;
	} item_t;

	typedef struct packed {
		logic [PHASE_W-1:0]  phase;
		logic [SUB_W-1:0]    sub_step;
		logic [BITCNT_W-1:0] bit_count;
		logic [7:0]          shift_byte;
		logic [VALUE_W-1:0]  gathered_value;
		logic [DELAY_W-1:0]  delay_count;
		logic                kind_latched;
		logic [7:0]          operand_latched;
		logic                scl_level;
		logic                sda_level;
	} st_t;

	typedef struct packed {
		logic               scl_drive;
		logic               sda_drive;
		logic               busy_res;
		logic               done_res;
		logic [VALUE_W-1:0] read_value;
	} res_t;

	localparam logic [PHASE_W-1:0] PHASE_IDLE = '0;
	localparam logic [PHASE_W-1:0] PHASE_LAST = 5'd20;

	// Segment run at a given phase; phase 0 and anything past the table is the end.
	function automatic seg_t seg_at(input logic kind, input logic [PHASE_W-1:0] phase);
		seg_t s;
		s = SEG_END;
		if (kind) begin
			unique case (phase)
				5'd1:  s = SEG_START;
				5'd2:  s = SEG_WR_ADDR_W;
				5'd3:  s = SEG_ACK;
				5'd4:  s = SEG_WR_CMDREG;
				5'd5:  s = SEG_ACK;
				5'd6:  s = SEG_WR_OPERAND;
				5'd7:  s = SEG_ACK;
				5'd8:  s = SEG_STOP;
				5'd9:  s = SEG_SETTLE;
				5'd10: s = SEG_WAITSCL;
				5'd11: s = SEG_START;
				5'd12: s = SEG_WR_ADDR_R;
				5'd13: s = SEG_ACK;
				5'd14: s = SEG_RD;
				5'd15: s = SEG_MACK;
				5'd16: s = SEG_RD;
				5'd17: s = SEG_NACK;
				5'd18: s = SEG_STOP;
				default: s = SEG_END;
			endcase
		end else begin
			unique case (phase)
				5'd1:  s = SEG_START;
				5'd2:  s = SEG_WR_ADDR_W;
				5'd3:  s = SEG_ACK;
				5'd4:  s = SEG_WR_OPERAND;
				5'd5:  s = SEG_ACK;
				5'd6:  s = SEG_START;
				5'd7:  s = SEG_WR_ADDR_R;
				5'd8:  s = SEG_ACK;
				5'd9:  s = SEG_RD;
				5'd10: s = SEG_NACK;
				5'd11: s = SEG_STOP;
				default: s = SEG_END;
			endcase
		end
		return s;
	endfunction

endpackage

[hdl/i2cst_if.sv]
// Request and result channel interfaces of the sensor I2C master.
interface i2cst_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic       start_request;
	logic [7:0] operand_byte;
	logic       sda_sample;
	logic       scl_sample;

	modport source (output valid, func, start_request, operand_byte, sda_sample, scl_sample,
		input ready);
	modport sink (input valid, func, start_request, operand_byte, sda_sample, scl_sample,
		output ready);
endinterface

interface i2cst_out_if;
	logic        valid;
	logic        ready;
	logic        scl_drive;
	logic        sda_drive;
	logic        busy_res;
	logic        done_res;
	logic [15:0] read_value;

	modport source (output valid, scl_drive, sda_drive, busy_res, done_res, read_value,
		input ready);
	modport sink (input valid, scl_drive, sda_drive, busy_res, done_res, read_value,
		output ready);
endinterface

[hdl/i2c_master_sensor_transactions_unit.sv]
// Top level of the tick-driven I2C master that runs sensor register and ranging transactions.
//
//  channel  | direction | carries
//  ---------+-----------+------------------------------------------------------------
//  in_ch    | sink      | one quarter-bit tick: func, start, operand, sampled SDA/SCL
//  res_ch   | source    | one result per tick: SCL/SDA drive, busy, done, read value
//  cfg_*    | write     | device address, command register, settle ticks
//
// Each request passes an input register and the sequencer step into the result register;
// one request is taken every cycle while the result side does not stall.
// The sequencer state feeds back on itself through its own register, which sets that rate.
// Reset returns the sequencer to idle with both lines released and default configuration.
// A stalled result holds the input register; a new request is taken whenever the
// input register is empty or moves on into the result register in the same cycle.
module i2c_master_sensor_transactions_unit
	import i2cst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	i2cst_in_if.sink             in_ch,
	i2cst_out_if.source          res_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	st_t   st_q;
	st_t   st_nx;
	res_t  res_nx;
	res_t  res_q;
	logic  res_valid_q;
	logic  advance;

	i2cst_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cst_step u_step (
		.st    (st_q),
		.item  (item_s1),
		.cfg   (cfg),
		.st_nx (st_nx),
		.res   (res_nx)
	);

	assign advance     = valid_s1 && (!res_valid_q || res_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.func          <= in_ch.func;
			item_s1.start_request <= in_ch.start_request;
			item_s1.operand_byte  <= in_ch.operand_byte;
			item_s1.sda_sample    <= in_ch.sda_sample;
			item_s1.scl_sample    <= in_ch.scl_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= PHASE_IDLE;
			st_q.sub_step        <= '0;
			st_q.bit_count       <= '0;
			st_q.shift_byte      <= '0;
			st_q.gathered_value  <= '0;
			st_q.delay_count     <= '0;
			st_q.kind_latched    <= 1'b0;
			st_q.operand_latched <= '0;
			st_q.scl_level       <= 1'b1;
			st_q.sda_level       <= 1'b1;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign res_ch.valid      = res_valid_q;
	assign res_ch.scl_drive  = res_q.scl_drive;
	assign res_ch.sda_drive  = res_q.sda_drive;
	assign res_ch.busy_res   = res_q.busy_res;
	assign res_ch.done_res   = res_q.done_res;
	assign res_ch.read_value = res_q.read_value;

	// A completed transaction always leaves the sequencer idle.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done result reported while still busy");

	// The phase never runs past PHASE_LAST, which lies beyond the end of the longest programme.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase <= PHASE_LAST)
		else $error("sequencer phase out of range");

	// Bit counter stays within one byte.
	a_bitcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_count <= BITS_PER_BYTE)
		else $error("bit counter overran a byte");

	// A request held in the input register is not lost while the result side stalls.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(st_q))
		else $error("stalled request dropped or state moved");

endmodule

[hdl/i2cst_cfg.sv]
// Configuration register bank of the sensor I2C master.
module i2cst_cfg
	import i2cst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address   <= 8'he0;
			cfg_q.command_register <= 8'h00;
			cfg_q.settle_ticks     <= 10'd40;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS:   cfg_q.device_address   <= cfg_data[7:0];
				REG_COMMAND_REGISTER: cfg_q.command_register <= cfg_data[7:0];
				REG_SETTLE_TICKS:     cfg_q.settle_ticks     <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/i2cst_step.sv]
// Next-state logic of the transaction sequencer for one quarter-bit tick.
module i2cst_step
	import i2cst_pkg::*;
(
	input  st_t   st,
	input  item_t item,
	input  cfg_t  cfg,
	output st_t   st_nx,
	output res_t  res
);

	always_comb begin
		st_t                 s;
		seg_t                seg;
		logic                fin;
		logic                done;
		logic [BITCNT_W-1:0] bit_inc;
		logic [DELAY_W-1:0]  delay_inc;
		logic [PHASE_W-1:0]  phase_inc;
		logic [7:0]          src;

		s    = st;
		fin  = 1'b0;
		done = 1'b0;

		if (s.phase == PHASE_IDLE && item.start_request) begin
			s.kind_latched    = item.func;
			s.operand_latched = item.operand_byte;
			s.gathered_value  = '0;
			s.phase           = 5'd1;
			s.sub_step        = '0;
			s.bit_count       = '0;
			s.delay_count     = '0;
		end

		seg       = seg_at(s.kind_latched, s.phase);
		bit_inc   = s.bit_count + 4'd1;
		delay_inc = s.delay_count + 10'd1;

		unique case (seg)
			SEG_WR_ADDR_W:  src = cfg.device_address & ADDR_WR_MASK;
			SEG_WR_ADDR_R:  src = cfg.device_address | ADDR_RD_BIT;
			SEG_WR_CMDREG:  src = cfg.command_register;
			default:        src = s.operand_latched;
		endcase

		if (s.phase != PHASE_IDLE) begin
			unique case (seg)
				SEG_START: begin
					unique case (s.sub_step)
						3'd0: s.sda_level = 1'b1;
						3'd1: s.scl_level = 1'b1;
						3'd2: s.sda_level = 1'b0;
						default: begin
							s.scl_level = 1'b0;
							fin = 1'b1;
						end
					endcase
					s.sub_step = s.sub_step + 3'd1;
				end
				SEG_STOP: begin
					unique case (s.sub_step)
						3'd0: s.sda_level = 1'b0;
						3'd1: s.scl_level = 1'b1;
						default: begin
							s.sda_level = 1'b1;
							fin = 1'b1;
						end
					endcase
					s.sub_step = s.sub_step + 3'd1;
				end
				SEG_WR_ADDR_W, SEG_WR_ADDR_R, SEG_WR_OPERAND, SEG_WR_CMDREG: begin
					unique case (s.sub_step)
						3'd0: begin
							if (s.bit_count == '0) s.shift_byte = src;
							s.scl_level = 1'b0;
							s.sub_step  = 3'd1;
						end
						3'd1: begin
							s.sda_level = s.shift_byte[7];
							s.sub_step  = 3'd2;
						end
						3'd2: begin
							s.scl_level  = 1'b1;
							s.shift_byte = {s.shift_byte[6:0], 1'b0};
							s.bit_count  = bit_inc;
							s.sub_step   = (bit_inc >= BITS_PER_BYTE) ? 3'd3 : 3'd0;
						end
						default: begin
							s.scl_level = 1'b0;
							fin = 1'b1;
						end
					endcase
				end
				SEG_ACK: begin
					if (s.sub_step == 3'd0) begin
						s.scl_level = 1'b1;
						s.sub_step  = 3'd1;
					end else if (!item.sda_sample) begin
						s.scl_level = 1'b0;
						fin = 1'b1;
					end
				end
				SEG_RD: begin
					unique case (s.sub_step)
						3'd0: begin
							s.scl_level = 1'b0;
							s.sub_step  = 3'd1;
						end
						3'd1: begin
							s.sda_level = 1'b1;
							s.sub_step  = 3'd2;
						end
						3'd2: begin
							s.scl_level = 1'b1;
							s.sub_step  = 3'd3;
						end
						3'd3: begin
							s.gathered_value = {s.gathered_value[VALUE_W-2:0], item.sda_sample};
							s.scl_level      = 1'b0;
							s.bit_count      = bit_inc;
							s.sub_step       = (bit_inc >= BITS_PER_BYTE) ? 3'd4 : 3'd2;
						end
						default: fin = 1'b1;
					endcase
				end
				SEG_MACK: begin
					unique case (s.sub_step)
						3'd0: s.scl_level = 1'b0;
						3'd1: s.sda_level = 1'b0;
						3'd2: s.scl_level = 1'b1;
						default: begin
							s.scl_level = 1'b0;
							fin = 1'b1;
						end
					endcase
					s.sub_step = s.sub_step + 3'd1;
				end
				SEG_NACK: begin
					unique case (s.sub_step)
						3'd0: s.scl_level = 1'b0;
						3'd1: begin
							s.sda_level = 1'b1;
							s.scl_level = 1'b1;
						end
						default: begin
							s.scl_level = 1'b0;
							fin = 1'b1;
						end
					endcase
					s.sub_step = s.sub_step + 3'd1;
				end
				SEG_SETTLE: begin
					s.delay_count = delay_inc;
					fin = (delay_inc >= cfg.settle_ticks);
				end
				SEG_WAITSCL: fin = item.scl_sample;
				default:     fin = 1'b1;
			endcase
		end

		phase_inc = s.phase + 5'd1;
		if (s.phase != PHASE_IDLE && fin) begin
			s.phase       = phase_inc;
			s.sub_step    = '0;
			s.bit_count   = '0;
			s.delay_count = '0;
			if (seg_at(s.kind_latched, phase_inc) == SEG_END) begin
				s.phase = PHASE_IDLE;
				done    = 1'b1;
			end
		end

		st_nx          = s;
		res.scl_drive  = s.scl_level;
		res.sda_drive  = s.sda_level;
		res.busy_res   = (s.phase != PHASE_IDLE);
		res.done_res   = done;
		res.read_value = s.gathered_value;
	end

endmodule
